### rtl/scs_pkg.sv
// ============================================================================
// scs_pkg
// Shared constants, types and elaboration-time math for the standoff
// circle selector.
// ============================================================================
package scs_pkg;

    typedef longint unsigned t_u64;

    // defaults for the top-level parameters
    localparam int DEF_MAX_COLS        = 256;
    localparam int DEF_MAX_ROWS        = 256;
    localparam int DEF_SAMPLE_COUNT    = 72;
    localparam int DEF_STANDOFF_RADIUS = 625;

    // field widths
    localparam int COORD_W  = 24;
    localparam int COST_W   = 8;
    localparam int COL_W    = 8;
    localparam int SAMPLE_W = 7;
    localparam int YAW_W    = 13;
    localparam int CS_W     = 16;
    localparam int GDIM_W   = 9;
    localparam int DIM_W    = 13;   // holds grid sizes up to 4096
    localparam int OFS_W    = 18;   // circle offsets, radius up to 65535

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd4;

    localparam logic [CS_W-1:0]   CELL_SIZE_RESET = 16'd51;
    localparam logic [GDIM_W-1:0] GRID_DIM_RESET  = 9'd256;

    // request commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Q30 constants
    localparam t_u64 ONE_Q30     = t_u64'(1) << 30;
    localparam t_u64 HALF_PI_Q30 = 64'd1686629713;
    localparam t_u64 PI_Q30      = 64'd3373259426;

    function automatic t_u64 mulq(input t_u64 a, input t_u64 b);
        return (a * b) >> 30;
    endfunction

    // sine series on 0..pi/4, Q30 in and out
    function automatic t_u64 ser_sin(input t_u64 x);
        t_u64 x2;
        t_u64 t;
        x2 = mulq(x, x);
        t  = ONE_Q30;
        t  = ONE_Q30 - mulq(x2, t) / 64'd72;
        t  = ONE_Q30 - mulq(x2, t) / 64'd42;
        t  = ONE_Q30 - mulq(x2, t) / 64'd20;
        t  = ONE_Q30 - mulq(x2, t) / 64'd6;
        return mulq(x, t);
    endfunction

    function automatic t_u64 ser_cos(input t_u64 x);
        t_u64 x2;
        t_u64 t;
        x2 = mulq(x, x);
        t  = ONE_Q30;
        t  = ONE_Q30 - mulq(x2, t) / 64'd56;
        t  = ONE_Q30 - mulq(x2, t) / 64'd30;
        t  = ONE_Q30 - mulq(x2, t) / 64'd12;
        t  = ONE_Q30 - mulq(x2, t) / 64'd2;
        return t;
    endfunction

    // cos (want_sin = 0) or sin of a 32-bit turn phase, Q30 signed
    function automatic longint cs_val(input t_u64 ph, input bit want_sin);
        t_u64   q;
        t_u64   r;
        t_u64   x;
        longint bc;
        longint bs;
        longint c;
        longint s;
        q = (ph >> 30) & 64'd3;
        r = ph & 64'h3FFF_FFFF;
        if (r > (t_u64'(1) << 29)) begin
            x  = ((ONE_Q30 - r) * HALF_PI_Q30) >> 30;
            bs = longint'(ser_cos(x));
            bc = longint'(ser_sin(x));
        end else begin
            x  = (r * HALF_PI_Q30) >> 30;
            bc = longint'(ser_cos(x));
            bs = longint'(ser_sin(x));
        end
        case (q)
            64'd0: begin c = bc;  s = bs;  end
            64'd1: begin c = -bs; s = bc;  end
            64'd2: begin c = -bc; s = -bs; end
            default: begin c = bs; s = -bc; end
        endcase
        return want_sin ? s : c;
    endfunction

    // divide by 2^30, rounded half away from zero
    function automatic longint rnd30(input longint v);
        t_u64 mag;
        t_u64 q;
        mag = (v < 0) ? t_u64'(-v) : t_u64'(v);
        q   = (mag + (t_u64'(1) << 29)) >> 30;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

endpackage

### rtl/scs_in_if.sv
// ============================================================================
// scs_in_if
// Request channel: grid cell write or standoff query.
// ============================================================================
interface scs_in_if
    import scs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic        [COL_W-1:0]    cell_col;
    logic        [COL_W-1:0]    cell_row;
    logic signed [COST_W-1:0]   cell_cost;
    logic signed [COORD_W-1:0]  button_x;
    logic signed [COORD_W-1:0]  button_y;
    logic signed [COORD_W-1:0]  robot_x;
    logic signed [COORD_W-1:0]  robot_y;

    modport source (
        output valid, cmd, cell_col, cell_row, cell_cost,
               button_x, button_y, robot_x, robot_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, cell_col, cell_row, cell_cost,
               button_x, button_y, robot_x, robot_y,
        output ready
    );
endinterface

### rtl/scs_out_if.sv
// ============================================================================
// scs_out_if
// Result channel: chosen standoff sample and heading.
// ============================================================================
interface scs_out_if
    import scs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic        [SAMPLE_W-1:0] best_sample;
    logic signed [YAW_W-1:0]    face_yaw;

    modport source (output valid, found, best_sample, face_yaw, input ready);
    modport sink   (input  valid, found, best_sample, face_yaw, output ready);
endinterface

### rtl/standoff_circle_selector_unit.sv
// ============================================================================
// standoff_circle_selector_unit
// Occupancy grid store with a standoff point search around a button.
// ============================================================================
// A write request (cmd = 0) stores one cost cell. A query
// request (cmd = 1) walks the SAMPLE_COUNT points of a circle of radius
// STANDOFF_RADIUS around the button, one point at a time, and answers with
// the free point nearest the robot and the heading that faces the button.
// The block is busy for the whole query. For each point on the grid the shared
// restoring divider turns its offset into a column and a row, one quotient
// bit a cycle (QB quotient bits, 8 for a 256 x 256 grid); the cell is then
// read and checked, and a free cell's squared distance to the robot is
// compared with the best so far. A point off the grid skips all of these.
// A point is kept only if it maps inside min(grid_width, MAX_COLS) by
// min(grid_height, MAX_ROWS) and its cell holds cost 0. Cells never written
// read as whatever the RAM holds. Config writes belong to idle periods.
// ============================================================================
module standoff_circle_selector_unit
    import scs_pkg::*;
#(
    parameter int MAX_COLS        = DEF_MAX_COLS,
    parameter int MAX_ROWS        = DEF_MAX_ROWS,
    parameter int SAMPLE_COUNT    = DEF_SAMPLE_COUNT,
    parameter int STANDOFF_RADIUS = DEF_STANDOFF_RADIUS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    scs_in_if.sink                i_req,
    scs_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CB  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RB  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QB  = (CB > RB) ? CB : RB;        // divider quotient bits
    localparam int KB  = $clog2(QB + 1);
    localparam int AW  = RB + CB;
    localparam int SB  = $clog2(SAMPLE_COUNT);
    localparam int DW  = (CS_W + QB > COORD_W + 1) ? CS_W + QB : COORD_W + 1;
    localparam int LW  = DIM_W + CS_W;
    localparam int GW  = COORD_W + 1;                // circle point
    localparam int XW  = COORD_W + 2;                // differences
    localparam int SQW = 2 * XW;

    // sequencer
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_SAMP  = 4'd2;
    localparam logic [3:0] ST_DIVX  = 4'd3;
    localparam logic [3:0] ST_DIVY  = 4'd4;
    localparam logic [3:0] ST_RD    = 4'd5;
    localparam logic [3:0] ST_CHK   = 4'd6;
    localparam logic [3:0] ST_SQY   = 4'd7;
    localparam logic [3:0] ST_CMP   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    // ---- circle tables, worked out at elaboration -------------------------
    logic signed [OFS_W-1:0] w_tdx  [SAMPLE_COUNT];
    logic signed [OFS_W-1:0] w_tdy  [SAMPLE_COUNT];
    logic signed [YAW_W-1:0] w_tyaw [SAMPLE_COUNT];

    for (genvar g = 0; g < SAMPLE_COUNT; g++) begin : g_tab
        localparam t_u64   PH  = (t_u64'(g) << 32) / t_u64'(SAMPLE_COUNT);
        localparam longint DXV = rnd30(longint'(STANDOFF_RADIUS) * cs_val(PH, 1'b0));
        localparam longint DYV = rnd30(longint'(STANDOFF_RADIUS) * cs_val(PH, 1'b1));
        localparam longint K   = (g == 0) ? longint'(SAMPLE_COUNT)
                                          : 2 * longint'(g) - longint'(SAMPLE_COUNT);
        localparam t_u64   KM  = t_u64'((K < 0) ? -K : K) * PI_Q30;
        localparam t_u64   DEN = t_u64'(SAMPLE_COUNT) << 20;
        localparam t_u64   YM  = (KM + DEN / 2) / DEN;
        localparam longint YV  = (K < 0) ? -longint'(YM) : longint'(YM);
        assign w_tdx[g]  = OFS_W'(DXV);
        assign w_tdy[g]  = OFS_W'(DYV);
        assign w_tyaw[g] = YAW_W'(YV);
    end

    // ---- registers ---------------------------------------------------------
    logic        [3:0]         r_state;
    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic        [CS_W-1:0]    r_cs;
    logic        [GDIM_W-1:0]  r_gw, r_gh;

    logic signed [COORD_W-1:0] r_bx, r_by, r_rx, r_ry;
    logic        [LW-1:0]      r_xlim, r_ylim;
    logic        [SB-1:0]      r_idx;
    logic signed [GW-1:0]      r_gx, r_gy;
    logic        [DW-1:0]      r_rem, r_rem_y, r_dvs;
    logic        [QB-1:0]      r_q, r_qx, r_qy;
    logic        [KB-1:0]      r_bit;
    logic        [COST_W-1:0]  r_rdata;
    logic        [SQW:0]       r_acc, r_dist, r_best_d;
    logic                      r_found;
    logic        [SB-1:0]      r_best;

    logic                      r_out_valid;
    logic                      r_out_found;
    logic        [SAMPLE_W-1:0] r_out_sample;
    logic signed [YAW_W-1:0]   r_out_yaw;

    logic [COST_W-1:0] r_mem [2**AW];

    // ---- datapath ----------------------------------------------------------
    logic              w_acc_req, w_wr_ok, w_last, w_fin_load, w_pt_ok, w_ge;
    logic [DIM_W-1:0]  w_wuse, w_huse;
    logic signed [GW-1:0] w_gx, w_gy;
    logic signed [XW-1:0] w_difx, w_dify, w_ddx, w_ddy, w_mop;
    logic signed [SQW-1:0] w_sq;
    logic [DW-1:0]     w_dvs0;
    logic [QB-1:0]     w_qn;
    logic [DW-1:0]     w_remn;
    logic [AW-1:0]     w_waddr, w_raddr;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc_req   = i_req.valid && i_req.ready;

    assign w_wr_ok = (DIM_W'(i_req.cell_col) < DIM_W'(MAX_COLS)) &&
                     (DIM_W'(i_req.cell_row) < DIM_W'(MAX_ROWS));
    assign w_waddr = {RB'(DIM_W'(i_req.cell_row)), CB'(DIM_W'(i_req.cell_col))};
    assign w_raddr = {r_qy[RB-1:0], r_qx[CB-1:0]};

    assign w_wuse = (DIM_W'(r_gw) < DIM_W'(MAX_COLS)) ? DIM_W'(r_gw) : DIM_W'(MAX_COLS);
    assign w_huse = (DIM_W'(r_gh) < DIM_W'(MAX_ROWS)) ? DIM_W'(r_gh) : DIM_W'(MAX_ROWS);

    // circle point and its offset from the grid origin
    assign w_gx   = GW'(r_bx) + GW'(w_tdx[r_idx]);
    assign w_gy   = GW'(r_by) + GW'(w_tdy[r_idx]);
    assign w_difx = XW'(w_gx) - XW'(r_ox);
    assign w_dify = XW'(w_gy) - XW'(r_oy);
    // a zero cell size gives zero limits, so every point fails here
    assign w_pt_ok = !w_difx[XW-1] && !w_dify[XW-1] &&
                     (LW'(w_difx[XW-2:0]) < r_xlim) &&
                     (LW'(w_dify[XW-2:0]) < r_ylim);

    // shared divider step: one quotient bit per cycle
    assign w_dvs0 = DW'(r_cs) << (QB - 1);
    assign w_ge   = (r_rem >= r_dvs);
    assign w_remn = w_ge ? (r_rem - r_dvs) : r_rem;
    assign w_qn   = (r_q << 1) | QB'(w_ge);

    // shared squarer
    assign w_ddx = XW'(r_gx) - XW'(r_rx);
    assign w_ddy = XW'(r_gy) - XW'(r_ry);
    assign w_mop = (r_state == ST_SQY) ? w_ddy : w_ddx;
    assign w_sq  = w_mop * w_mop;

    assign w_last     = (r_idx == SB'(SAMPLE_COUNT - 1));
    assign w_fin_load = (r_state == ST_FIN) && (!r_out_valid || o_res.ready);

    // ---- grid RAM ----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_acc_req && i_req.cmd == CMD_WRITE && w_wr_ok) begin
            r_mem[w_waddr] <= i_req.cell_cost;
        end
        if (r_state == ST_RD) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // ---- configuration -----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0;
            r_oy <= '0;
            r_cs <= CELL_SIZE_RESET;
            r_gw <= GRID_DIM_RESET;
            r_gh <= GRID_DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X:    r_ox <= i_cfg_data;
                CFG_ORIGIN_Y:    r_oy <= i_cfg_data;
                CFG_CELL_SIZE:   r_cs <= i_cfg_data[CS_W-1:0];
                CFG_GRID_WIDTH:  r_gw <= i_cfg_data[GDIM_W-1:0];
                CFG_GRID_HEIGHT: r_gh <= i_cfg_data[GDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- sequencer ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc_req && i_req.cmd == CMD_QUERY) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_state <= ST_SAMP;
                end
                ST_SAMP: begin
                    if (w_pt_ok) begin
                        r_state <= ST_DIVX;
                    end else if (w_last) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DIVX: begin
                    if (r_bit == '0) r_state <= ST_DIVY;
                end
                ST_DIVY: begin
                    if (r_bit == '0) r_state <= ST_RD;
                end
                ST_RD: r_state <= ST_CHK;
                ST_CHK: begin
                    if (r_rdata == '0) begin
                        r_state <= ST_SQY;
                    end else if (w_last) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_SAMP;
                    end
                end
                ST_SQY: r_state <= ST_CMP;
                ST_CMP: begin
                    if (!r_found || r_dist < r_best_d) begin
                        r_found <= 1'b1;
                    end
                    if (w_last) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_SAMP;
                    end
                end
                ST_FIN: begin
                    if (w_fin_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---- working registers (no reset) --------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_acc_req) begin
            r_bx <= i_req.button_x;
            r_by <= i_req.button_y;
            r_rx <= i_req.robot_x;
            r_ry <= i_req.robot_y;
        end
        case (r_state)
            ST_SETUP: begin
                r_xlim <= LW'(w_wuse) * LW'(r_cs);
                r_ylim <= LW'(w_huse) * LW'(r_cs);
            end
            ST_SAMP: begin
                r_gx    <= w_gx;
                r_gy    <= w_gy;
                r_rem   <= DW'(w_difx[XW-2:0]);
                r_rem_y <= DW'(w_dify[XW-2:0]);
                r_dvs   <= w_dvs0;
                r_q     <= '0;
                r_bit   <= KB'(QB - 1);
            end
            ST_DIVX: begin
                if (r_bit == '0) begin
                    r_qx  <= w_qn;
                    r_rem <= r_rem_y;
                    r_dvs <= w_dvs0;
                    r_q   <= '0;
                    r_bit <= KB'(QB - 1);
                end else begin
                    r_rem <= w_remn;
                    r_dvs <= r_dvs >> 1;
                    r_q   <= w_qn;
                    r_bit <= r_bit - 1'b1;
                end
            end
            ST_DIVY: begin
                r_rem <= w_remn;
                r_dvs <= r_dvs >> 1;
                r_q   <= w_qn;
                r_bit <= r_bit - 1'b1;
                if (r_bit == '0) r_qy <= w_qn;
            end
            ST_CHK: r_acc  <= (SQW + 1)'($unsigned(w_sq));
            ST_SQY: r_dist <= r_acc + (SQW + 1)'($unsigned(w_sq));
            ST_CMP: begin
                if (!r_found || r_dist < r_best_d) begin
                    r_best_d <= r_dist;
                    r_best   <= r_idx;
                end
            end
            default: ;
        endcase
    end

    // ---- result register ---------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out_found  <= r_found;
            r_out_sample <= r_found ? SAMPLE_W'(r_best) : '0;
            r_out_yaw    <= r_found ? w_tyaw[r_best] : '0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_out_found;
    assign o_res.best_sample = r_out_sample;
    assign o_res.face_yaw    = r_out_yaw;

`ifndef NO_ASSERTIONS
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_req && i_req.cmd == CMD_QUERY) |=> !i_req.ready)
        else $error("query accepted but block still ready");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |-> (o_res.best_sample == '0 && o_res.face_yaw == '0))
        else $error("empty result carries nonzero fields");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAMP) |-> (r_idx <= SB'(SAMPLE_COUNT - 1)))
        else $error("sample index out of range");

    a_div_to_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> $past(r_state) == ST_DIVY)
        else $error("grid read without finished division");
`endif

endmodule
